// File: rtl/core/jsu_pkg.sv
package jsu_pkg;

    // Result error codes.
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_HEX  = 2'd1;
    localparam logic [1:0] ERR_SURR = 2'd2;

    // Characters that the decoder looks for.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = "b";
    localparam logic [7:0] CH_F      = "f";
    localparam logic [7:0] CH_N      = "n";
    localparam logic [7:0] CH_R      = "r";
    localparam logic [7:0] CH_T      = "t";
    localparam logic [7:0] CH_U      = "u";
    localparam logic [7:0] CH_0      = "0";
    localparam logic [7:0] CH_9      = "9";
    localparam logic [7:0] CH_LA     = "a";
    localparam logic [7:0] CH_LF     = "f";
    localparam logic [7:0] CH_UA     = "A";
    localparam logic [7:0] CH_UF     = "F";

    // Control codes that the short escapes stand for.
    localparam logic [7:0] CODE_BS = 8'h08;
    localparam logic [7:0] CODE_FF = 8'h0C;
    localparam logic [7:0] CODE_LF = 8'h0A;
    localparam logic [7:0] CODE_CR = 8'h0D;
    localparam logic [7:0] CODE_HT = 8'h09;

    // Top six bits of a UTF-16 high and low surrogate.
    localparam logic [5:0] SURR_HI_TAG = 6'b110110;
    localparam logic [5:0] SURR_LO_TAG = 6'b110111;

    // Run queue between the decoder and the result sequencer.
    localparam int RUN_DEPTH = 4;
    localparam int RUN_PTR_W = $clog2(RUN_DEPTH);
    localparam int RUN_CNT_W = $clog2(RUN_DEPTH + 1);

    // One input beat.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } jsu_in_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] error_code;
        logic       last_of_run;
        logic       end_of_string;
    } jsu_out_t;

    // UTF-8 encoding of one code point, first byte in slot 0.
    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] bytes;
    } jsu_utf8_t;

    // All results caused by one input byte. A status run has one result.
    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] bytes;
        logic            status;
        logic [1:0]      err;
        logic            eos;
    } jsu_run_t;

    // Push side of the run queue.
    typedef struct packed {
        logic     push;
        jsu_run_t run;
    } jsu_push_t;

    // Head of the run queue as the sequencer sees it.
    typedef struct packed {
        logic     valid;
        jsu_run_t run;
    } jsu_head_t;

    // Hex digit value, or bit 4 set for a non-hex character.
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= CH_0 && c <= CH_9) begin
            r = {1'b0, 4'(c - CH_0)};
        end else if (c >= CH_LA && c <= CH_LF) begin
            r = {1'b0, 4'(c - CH_LA + 8'd10)};
        end else if (c >= CH_UA && c <= CH_UF) begin
            r = {1'b0, 4'(c - CH_UA + 8'd10)};
        end
        return r;
    endfunction

    // UTF-8 encoder for code points up to 21 bits.
    function automatic jsu_utf8_t utf8_of(input logic [20:0] cp);
        jsu_utf8_t r;
        r = '0;
        if (cp < 21'h80) begin
            r.cnt      = 3'd1;
            r.bytes[0] = {1'b0, cp[6:0]};
        end else if (cp < 21'h800) begin
            r.cnt      = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            r.cnt      = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.cnt      = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

// File: rtl/core/jsu_front.sv
module jsu_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid,
    output logic             stall,
    input  jsu_pkg::jsu_in_t data,
    input  logic             full,
    output jsu_pkg::jsu_push_t wr
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        PH_NORMAL,
        PH_ESC,
        PH_HEX,
        PH_WANT_BS,
        PH_WANT_U,
        PH_HEX2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] hex_reg, hex_next;
    logic [1:0]  digits_reg, digits_next;
    logic [9:0]  high_reg, high_next;
    logic        failed_reg, failed_next;

    logic        accept;
    logic [4:0]  digit;
    logic [15:0] hex_new;
    logic [20:0] pair_cp;
    jsu_utf8_t   enc_single;
    jsu_utf8_t   enc_pair;
    logic [1:0]  err;
    jsu_run_t    run;

    assign stall  = full;
    assign accept = valid && !full;

    // Digit decode and the two possible code points of a finished unit.
    assign digit      = hex_of(data.in_byte);
    assign hex_new    = {hex_reg[11:0], digit[3:0]};
    assign pair_cp    = (21'({high_reg, 10'b0}) + 21'h10000) | {11'b0, hex_new[9:0]};
    assign enc_single = utf8_of({5'b0, hex_new});
    assign enc_pair   = utf8_of(pair_cp);

    // Escape decoder: next state and the run of results for this byte.
    always_comb
    begin
        phase_next  = phase_reg;
        hex_next    = hex_reg;
        digits_next = digits_reg;
        high_next   = high_reg;
        failed_next = failed_reg;
        err         = ERR_NONE;
        run         = '0;

        if (!failed_reg) begin
            unique case (phase_reg)
                PH_ESC:
                begin
                    phase_next = PH_NORMAL;
                    run.cnt    = 3'd1;
                    unique case (data.in_byte)
                        CH_B:    run.bytes[0] = CODE_BS;
                        CH_F:    run.bytes[0] = CODE_FF;
                        CH_N:    run.bytes[0] = CODE_LF;
                        CH_R:    run.bytes[0] = CODE_CR;
                        CH_T:    run.bytes[0] = CODE_HT;
                        CH_U:
                        begin
                            run.cnt     = 3'd0;
                            phase_next  = PH_HEX;
                            hex_next    = '0;
                            digits_next = '0;
                        end
                        default: run.bytes[0] = data.in_byte;
                    endcase
                end
                PH_HEX, PH_HEX2:
                begin
                    if (digit[4]) begin
                        err = ERR_HEX;
                    end else begin
                        hex_next = hex_new;
                        if (digits_reg != 2'd3) begin
                            digits_next = digits_reg + 2'd1;
                        end else begin
                            digits_next = '0;
                            if (phase_reg == PH_HEX) begin
                                if (hex_new[15:10] == SURR_HI_TAG) begin
                                    high_next  = hex_new[9:0];
                                    phase_next = PH_WANT_BS;
                                end else if (hex_new[15:10] == SURR_LO_TAG) begin
                                    err = ERR_SURR;
                                end else begin
                                    run.cnt    = enc_single.cnt;
                                    run.bytes  = enc_single.bytes;
                                    phase_next = PH_NORMAL;
                                end
                            end else begin
                                if (hex_new[15:10] == SURR_LO_TAG) begin
                                    run.cnt    = enc_pair.cnt;
                                    run.bytes  = enc_pair.bytes;
                                    phase_next = PH_NORMAL;
                                end else begin
                                    err = ERR_SURR;
                                end
                            end
                        end
                    end
                end
                PH_WANT_BS:
                begin
                    if (data.in_byte == CH_BSLASH) begin
                        phase_next = PH_WANT_U;
                    end else begin
                        err = ERR_SURR;
                    end
                end
                PH_WANT_U:
                begin
                    if (data.in_byte == CH_U) begin
                        phase_next  = PH_HEX2;
                        hex_next    = '0;
                        digits_next = '0;
                    end else begin
                        err = ERR_SURR;
                    end
                end
                default:
                begin
                    phase_next = PH_NORMAL;
                    if (data.in_byte == CH_BSLASH) begin
                        phase_next = PH_ESC;
                    end else begin
                        run.cnt      = 3'd1;
                        run.bytes[0] = data.in_byte;
                    end
                end
            endcase

            // A string that ends inside a unicode escape or a surrogate pair is an error.
            if (err == ERR_NONE && data.end_of_input) begin
                if (phase_next == PH_HEX || phase_next == PH_HEX2) begin
                    err = ERR_HEX;
                end else if (phase_next == PH_WANT_BS || phase_next == PH_WANT_U) begin
                    err = ERR_SURR;
                end
            end

            // An error is reported once as a status result.
            if (err != ERR_NONE) begin
                run.cnt     = 3'd1;
                run.bytes   = '0;
                run.status  = 1'b1;
                run.err     = err;
                failed_next = 1'b1;
            end
        end

        // The end byte always gives at least one result and clears the state.
        if (data.end_of_input) begin
            if (run.cnt == 3'd0) begin
                run.cnt    = 3'd1;
                run.status = 1'b1;
                run.err    = ERR_NONE;
            end
            run.eos     = 1'b1;
            phase_next  = PH_NORMAL;
            hex_next    = '0;
            digits_next = '0;
            high_next   = '0;
            failed_next = 1'b0;
        end
    end

    assign wr.push = accept && (run.cnt != 3'd0);
    assign wr.run  = run;

    // Decoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_NORMAL;
            hex_reg    <= '0;
            digits_reg <= '0;
            high_reg   <= '0;
            failed_reg <= 1'b0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            hex_reg    <= hex_next;
            digits_reg <= digits_next;
            high_reg   <= high_next;
            failed_reg <= failed_next;
        end
    end

    // The end of a string leaves the decoder as after reset.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && data.end_of_input |=>
            phase_reg == PH_NORMAL && !failed_reg && digits_reg == 2'd0)
        else $error("decoder state not cleared after end of string");

    // After an error only the end byte produces a result.
    a_failed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        accept && failed_reg && !data.end_of_input |-> !wr.push)
        else $error("result pushed after an error");

    // The failed flag is only set by a pushed error report.
    a_failed_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(failed_reg) |-> $past(wr.push) && $past(wr.run.err) != ERR_NONE)
        else $error("failed flag set without an error report");

endmodule

// File: rtl/core/jsu_run_fifo.sv
module jsu_run_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  jsu_pkg::jsu_push_t wr,
    input  logic               pop,
    output logic               full,
    output jsu_pkg::jsu_head_t head
);
    import jsu_pkg::*;

    jsu_run_t             entry_reg [RUN_DEPTH];
    logic [RUN_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RUN_CNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == RUN_CNT_W'(RUN_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.run   = entry_reg[rd_ptr_reg];

    // Occupancy after this cycle's push and pop.
    always_comb
    begin
        count_next = count_reg;
        if (wr.push && !pop) begin
            count_next = count_reg + RUN_CNT_W'(1);
        end else if (!wr.push && pop) begin
            count_next = count_reg - RUN_CNT_W'(1);
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr.push) begin
            entry_reg[wr_ptr_reg] <= wr.run;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr.push) begin
                wr_ptr_reg <= wr_ptr_reg + RUN_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + RUN_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Occupancy never passes the depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RUN_CNT_W'(RUN_DEPTH))
        else $error("run queue count out of range");

    // No write into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr.push |-> !full)
        else $error("run queue overflow");

    // No read from an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("run queue underflow");

endmodule

// File: rtl/core/jsu_back.sv
module jsu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  jsu_pkg::jsu_head_t head,
    output logic               pop,
    output logic               valid,
    input  logic               stall,
    output jsu_pkg::jsu_out_t  data
);
    import jsu_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    jsu_out_t   out_reg;
    jsu_out_t   item;
    logic       load;
    logic       is_last;

    // Pick the current result of the run at the queue head.
    assign is_last = idx_reg == 2'(head.run.cnt - 3'd1);
    assign load    = head.valid && (!out_valid_reg || !stall);
    assign pop     = load && is_last;

    always_comb
    begin
        item.out_byte      = head.run.status ? 8'h00 : head.run.bytes[idx_reg];
        item.byte_valid    = !head.run.status;
        item.error_code    = head.run.status ? head.run.err : ERR_NONE;
        item.last_of_run   = is_last;
        item.end_of_string = is_last && head.run.eos;
    end

    // Next index and output register occupancy.
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && stall;
        if (load) begin
            idx_next       = is_last ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load) begin
            out_reg <= item;
        end
    end

    assign valid = out_valid_reg;
    assign data  = out_reg;

    // End of string always closes a run.
    a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && data.end_of_string |-> data.last_of_run)
        else $error("end of string not on the last result of a run");

    // Status results carry a zero byte, data results no error.
    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (data.byte_valid && data.error_code == ERR_NONE) ||
                  (!data.byte_valid && data.out_byte == 8'h00))
        else $error("malformed result beat");

    // The index returns to zero whenever a run is finished.
    a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> idx_reg == 2'd0)
        else $error("run index not reset after the last result");

endmodule

// File: rtl/core/json_string_unescaper_top.sv
// The results of an accepted byte go through the run queue into the registered output of the sequencer.
// Throughput: one byte per cycle while the run queue is not full; the result side drains
// one beat per cycle while dec_stall is low, so a byte giving N results (up to four)
// takes N output beats, and a four-run queue between decoder and sequencer absorbs them.
// Reset: asynchronous, active low; it clears the decoder state, the queue and the output.
module json_string_unescaper_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              raw_valid,
    output logic              raw_stall,
    input  jsu_pkg::jsu_in_t  raw_data,
    output logic              dec_valid,
    input  logic              dec_stall,
    output jsu_pkg::jsu_out_t dec_data
);
    import jsu_pkg::*;

    jsu_push_t wr;
    jsu_head_t head;
    logic      full;
    logic      pop;

    // Escape decoder.
    jsu_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (raw_valid),
        .stall (raw_stall),
        .data  (raw_data),
        .full  (full),
        .wr    (wr)
    );

    // Queue of result runs.
    jsu_run_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .pop   (pop),
        .full  (full),
        .head  (head)
    );

    // Result sequencer.
    jsu_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .valid (dec_valid),
        .stall (dec_stall),
        .data  (dec_data)
    );

endmodule

// File: tb/jsu_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the unescaper, predicts the result beats of every
// accepted raw beat and compares them in order with the beats that come out.
module jsu_checker
    import jsu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     raw_valid,
    input  logic     raw_stall,
    input  jsu_in_t  raw_data,
    input  logic     dec_valid,
    input  logic     dec_stall,
    input  jsu_out_t dec_data,
    output int       fail_count,
    output int       open_count,
    output int       result_count
);

    // Where the decoder stands inside an escape sequence.
    typedef enum logic [2:0] {
        PH_TEXT,
        PH_ESC,
        PH_HEX,
        PH_WANT_BS,
        PH_WANT_U,
        PH_HEX2
    } esc_phase_t;

    esc_phase_t  esc_phase;
    logic [15:0] hex_acc;
    logic [1:0]  digit_cnt;
    logic [9:0]  high_bits;
    logic        string_dead;

    // Unescaped beats still owed by the block, oldest first.
    jsu_out_t unescaped_q[$];
    // Beats caused by the raw beat being decoded right now.
    jsu_out_t run_q[$];

    // Value of a hex digit; bit 4 set when the character is not one.
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        if (c inside {[CH_0:CH_9]}) begin
            return {1'b0, c[3:0]};
        end
        if (c inside {[CH_LA:CH_LF]} || c inside {[CH_UA:CH_UF]}) begin
            return {1'b0, c[3:0] + 4'd9};
        end
        return 5'h10;
    endfunction

    task automatic clear_decoder();
        esc_phase   = PH_TEXT;
        hex_acc     = '0;
        digit_cnt   = '0;
        high_bits   = '0;
        string_dead = 1'b0;
    endtask

    task automatic push_result(input logic [7:0] b, input logic vld, input logic [1:0] err);
        jsu_out_t r;
        r            = '0;
        r.out_byte   = b;
        r.byte_valid = vld;
        r.error_code = err;
        run_q.push_back(r);
    endtask

    // UTF-8: a lead byte followed by six-bit continuation bytes, high bits first.
    task automatic push_code_point(input logic [20:0] cp);
        int         extra;
        logic [7:0] lead;
        if (cp < 21'h80) begin
            extra = 0;
            lead  = 8'h00;
        end else if (cp < 21'h800) begin
            extra = 1;
            lead  = 8'hC0;
        end else if (cp < 21'h10000) begin
            extra = 2;
            lead  = 8'hE0;
        end else begin
            extra = 3;
            lead  = 8'hF0;
        end
        push_result(lead | 8'(cp >> (6 * extra)), 1'b1, ERR_NONE);
        for (int i = extra - 1; i >= 0; i--) begin
            push_result(8'h80 | 8'((cp >> (6 * i)) & 21'h3F), 1'b1, ERR_NONE);
        end
    endtask

    // Decodes one raw beat and queues the result beats that it causes.
    task automatic decode_raw_beat(input jsu_in_t beat);
        logic [7:0]  c;
        logic [1:0]  err;
        logic [4:0]  dig;
        logic [15:0] unit;
        int          tail;
        c   = beat.in_byte;
        err = ERR_NONE;
        run_q.delete();

        if (!string_dead) begin
            case (esc_phase)
                PH_ESC:
                begin
                    esc_phase = PH_TEXT;
                    case (c)
                        CH_B: push_result(CODE_BS, 1'b1, ERR_NONE);
                        CH_F: push_result(CODE_FF, 1'b1, ERR_NONE);
                        CH_N: push_result(CODE_LF, 1'b1, ERR_NONE);
                        CH_R: push_result(CODE_CR, 1'b1, ERR_NONE);
                        CH_T: push_result(CODE_HT, 1'b1, ERR_NONE);
                        CH_U:
                        begin
                            esc_phase = PH_HEX;
                            hex_acc   = '0;
                            digit_cnt = '0;
                        end
                        default: push_result(c, 1'b1, ERR_NONE);
                    endcase
                end
                PH_HEX, PH_HEX2:
                begin
                    dig = digit_value(c);
                    if (dig[4]) begin
                        err = ERR_HEX;
                    end else begin
                        unit    = {hex_acc[11:0], dig[3:0]};
                        hex_acc = unit;
                        if (digit_cnt != 2'd3) begin
                            digit_cnt++;
                        end else begin
                            digit_cnt = '0;
                            // A full unit: the first one may open a pair, the
                            // second one must close it.
                            if (esc_phase == PH_HEX) begin
                                if (unit[15:10] == SURR_HI_TAG) begin
                                    high_bits = unit[9:0];
                                    esc_phase = PH_WANT_BS;
                                end else if (unit[15:10] == SURR_LO_TAG) begin
                                    err = ERR_SURR;
                                end else begin
                                    push_code_point({5'b0, unit});
                                    esc_phase = PH_TEXT;
                                end
                            end else if (unit[15:10] == SURR_LO_TAG) begin
                                push_code_point(21'h10000 + {high_bits, unit[9:0]});
                                esc_phase = PH_TEXT;
                            end else begin
                                err = ERR_SURR;
                            end
                        end
                    end
                end
                PH_WANT_BS:
                begin
                    if (c == CH_BSLASH) esc_phase = PH_WANT_U;
                    else err = ERR_SURR;
                end
                PH_WANT_U:
                begin
                    if (c == CH_U) begin
                        esc_phase = PH_HEX2;
                        hex_acc   = '0;
                        digit_cnt = '0;
                    end else begin
                        err = ERR_SURR;
                    end
                end
                default:
                begin
                    if (c == CH_BSLASH) esc_phase = PH_ESC;
                    else push_result(c, 1'b1, ERR_NONE);
                end
            endcase

            // A string that stops inside a unicode escape is an error too.
            if (err == ERR_NONE && beat.end_of_input) begin
                if (esc_phase inside {PH_HEX, PH_HEX2}) err = ERR_HEX;
                else if (esc_phase inside {PH_WANT_BS, PH_WANT_U}) err = ERR_SURR;
            end
            if (err != ERR_NONE) begin
                push_result(8'h00, 1'b0, err);
                string_dead = 1'b1;
            end
        end

        if (beat.end_of_input) begin
            if (run_q.size() == 0) push_result(8'h00, 1'b0, ERR_NONE);
            tail = run_q.size() - 1;
            run_q[tail].end_of_string = 1'b1;
            clear_decoder();
        end
        if (run_q.size() != 0) begin
            tail = run_q.size() - 1;
            run_q[tail].last_of_run = 1'b1;
        end
        foreach (run_q[i]) unescaped_q.push_back(run_q[i]);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Compare the outgoing beat first, then predict from the incoming one.
    always @(posedge clk or negedge rst_n)
    begin
        jsu_out_t want;
        if (!rst_n) begin
            clear_decoder();
            unescaped_q.delete();
            open_count = 0;
        end else begin
            if (dec_valid && !dec_stall) begin
                result_count++;
                if (unescaped_q.size() == 0) begin
                    $error("result beat with nothing expected: out_byte %0h", dec_data.out_byte);
                    fail_count++;
                end else begin
                    want = unescaped_q.pop_front();
                    check_field("out_byte", want.out_byte, dec_data.out_byte);
                    check_field("byte_valid", 8'(want.byte_valid), 8'(dec_data.byte_valid));
                    check_field("error_code", 8'(want.error_code), 8'(dec_data.error_code));
                    check_field("last_of_run", 8'(want.last_of_run),
                                8'(dec_data.last_of_run));
                    check_field("end_of_string", 8'(want.end_of_string),
                                8'(dec_data.end_of_string));
                end
            end
            if (raw_valid && !raw_stall) decode_raw_beat(raw_data);
            open_count = unescaped_q.size();
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import jsu_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     raw_valid;
    logic     raw_stall;
    jsu_in_t  raw_data;
    logic     dec_valid;
    logic     dec_stall = 1'b0;
    jsu_out_t dec_data;

    int fail_count;
    int open_count;
    int result_count;

    // No idling on either side while calm is set.
    logic calm = 1'b0;
    int   beats_sent;
    int   strings_sent;
    int   random_beats;

    // Raw bytes of the string being built.
    logic [7:0] text_q[$];

    json_string_unescaper_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw_valid),
        .raw_stall (raw_stall),
        .raw_data  (raw_data),
        .dec_valid (dec_valid),
        .dec_stall (dec_stall),
        .dec_data  (dec_data)
    );

    jsu_checker decode_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .raw_valid    (raw_valid),
        .raw_stall    (raw_stall),
        .raw_data     (raw_data),
        .dec_valid    (dec_valid),
        .dec_stall    (dec_stall),
        .dec_data     (dec_data),
        .fail_count   (fail_count),
        .open_count   (open_count),
        .result_count (result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The result side stalls at random outside the calm stretch.
    always @(negedge clk)
    begin
        dec_stall <= !calm && ($urandom_range(99) < 18);
    end

    // Hex digit character, letters in either case.
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return CH_0 + 8'(v);
        return ($urandom_range(1) ? CH_LA : CH_UA) + 8'(v) - 8'd10;
    endfunction

    function automatic bit is_hex_char(input logic [7:0] c);
        return (c inside {[CH_0:CH_9]}) || (c inside {[CH_LA:CH_LF]}) ||
               (c inside {[CH_UA:CH_UF]});
    endfunction

    // Random value in a range, with the two ends of the range favored.
    function automatic logic [15:0] pick_in(input logic [15:0] lo, input logic [15:0] hi);
        int r;
        r = $urandom_range(7);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return 16'($urandom_range(hi, lo));
    endfunction

    task automatic add_unit(input logic [15:0] v);
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_U);
        for (int i = 3; i >= 0; i--) text_q.push_back(hex_char(v[4 * i +: 4]));
    endtask

    // Appends one random piece of string text. Mostly well-formed text and
    // escapes; the rest breaks an escape. Sets cut when the string must end here.
    task automatic add_token(output bit cut);
        int         pick;
        int         start;
        int         keep;
        logic [7:0] c;
        logic [15:0] v;
        cut  = 1'b0;
        pick = $urandom_range(99);
        if (pick < 30) begin
            // Plain byte; a backslash goes in doubled.
            c = 8'($urandom_range(255));
            if (c == CH_BSLASH) text_q.push_back(CH_BSLASH);
            text_q.push_back(c);
        end else if (pick < 45) begin
            text_q.push_back(CH_BSLASH);
            case ($urandom_range(4))
                0: text_q.push_back(CH_B);
                1: text_q.push_back(CH_F);
                2: text_q.push_back(CH_N);
                3: text_q.push_back(CH_R);
                default: text_q.push_back(CH_T);
            endcase
        end else if (pick < 52) begin
            // Escaped character: itself, or a control code for b, f, n, r, t.
            c = 8'($urandom_range(255));
            if (c == CH_U) c = "/";
            text_q.push_back(CH_BSLASH);
            text_q.push_back(c);
        end else if (pick < 72) begin
            case ($urandom_range(3))
                0: v = pick_in(16'h0000, 16'h007F);
                1: v = pick_in(16'h0080, 16'h07FF);
                2: v = pick_in(16'h0800, 16'hD7FF);
                default: v = pick_in(16'hE000, 16'hFFFF);
            endcase
            add_unit(v);
        end else if (pick < 87) begin
            add_unit(pick_in(16'hD800, 16'hDBFF));
            add_unit(pick_in(16'hDC00, 16'hDFFF));
        end else begin
            case ($urandom_range(5))
                0:
                begin
                    // Non-hex character among the digits, in a first or second unit.
                    if ($urandom_range(1)) add_unit(pick_in(16'hD800, 16'hDBFF));
                    text_q.push_back(CH_BSLASH);
                    text_q.push_back(CH_U);
                    repeat ($urandom_range(3)) text_q.push_back(hex_char(4'($urandom_range(15))));
                    do c = 8'($urandom_range(255)); while (is_hex_char(c));
                    text_q.push_back(c);
                end
                1: add_unit(pick_in(16'hDC00, 16'hDFFF));
                2:
                begin
                    add_unit(pick_in(16'hD800, 16'hDBFF));
                    c = 8'($urandom_range(255));
                    if (c == CH_BSLASH) c = "x";
                    text_q.push_back(c);
                end
                3:
                begin
                    add_unit(pick_in(16'hD800, 16'hDBFF));
                    text_q.push_back(CH_BSLASH);
                    c = 8'($urandom_range(255));
                    if (c == CH_U) c = "v";
                    text_q.push_back(c);
                end
                4:
                begin
                    add_unit(pick_in(16'hD800, 16'hDBFF));
                    v = $urandom_range(1) ? pick_in(16'h0000, 16'hDBFF) :
                                            pick_in(16'hE000, 16'hFFFF);
                    add_unit(v);
                end
                default:
                begin
                    // String stops somewhere inside a unicode escape or a pair.
                    start = text_q.size();
                    if ($urandom_range(1)) begin
                        add_unit(pick_in(16'hD800, 16'hDBFF));
                        add_unit(pick_in(16'hDC00, 16'hDFFF));
                    end else begin
                        add_unit(16'($urandom_range(16'hFFFF)));
                    end
                    keep = $urandom_range(text_q.size() - start - 1, 1);
                    while (text_q.size() > start + keep) void'(text_q.pop_back());
                    cut = 1'b1;
                end
            endcase
        end
    endtask

    // Sends the built string one beat at a time, the last beat marked as the end.
    task automatic send_text();
        jsu_in_t beat;
        for (int i = 0; i < text_q.size(); i++) begin
            // Each cycle before a beat idles with the same small chance.
            while (!calm && $urandom_range(99) < 18)
            begin
                @(negedge clk);
                raw_valid <= 1'b0;
            end
            beat.in_byte      = text_q[i];
            beat.end_of_input = (i == text_q.size() - 1);
            @(negedge clk);
            raw_valid <= 1'b1;
            raw_data  <= beat;
            @(posedge clk);
            while (raw_stall) @(posedge clk);
            beats_sent++;
        end
        strings_sent++;
        text_q.delete();
    endtask

    initial
    begin
        int tokens;
        bit cut;
        rst_n     = 1'b0;
        raw_valid = 1'b0;
        raw_data  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed strings: extreme bytes with a trailing backslash, every short
        // escape, a lone low surrogate, a truncated escape and a bad hex digit
        // followed by a byte that must be dropped.
        text_q = '{8'h00, 8'hFF, CH_BSLASH};
        send_text();
        text_q = '{CH_BSLASH, CH_B, CH_BSLASH, CH_F, CH_BSLASH, CH_N,
                   CH_BSLASH, CH_R, CH_BSLASH, CH_T};
        send_text();
        add_unit(16'hDC00);
        send_text();
        text_q = '{CH_BSLASH, CH_U, "4"};
        send_text();
        text_q = '{CH_BSLASH, CH_U, CH_0, "x", "A"};
        send_text();

        // Random strings, with a stretch in the middle where nobody idles.
        while (random_beats < 125) begin
            calm   = (random_beats >= 45 && random_beats < 85);
            tokens = $urandom_range(5, 1);
            cut    = 1'b0;
            for (int t = 0; t < tokens && !cut; t++) add_token(cut);
            random_beats += text_q.size();
            send_text();
        end
        calm = 1'b0;
        @(negedge clk);
        raw_valid <= 1'b0;

        while (open_count != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (open_count != 0) $error("%0d expected result beats never arrived", open_count);

        $display("Sent %0d raw beats in %0d strings: plain text, escapes, unicode units,",
                 beats_sent, strings_sent);
        $display("surrogate pairs and broken escapes; %0d result beats compared.",
                 result_count);
        if (fail_count == 0 && open_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
